>>> hw/rtl/slps_pkg.sv
// Shared types, codes and the segment table of the status LED sequencer.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package slps_pkg;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_SET_BASE = 2'd1;
    localparam logic [1:0] OP_FLASH    = 2'd2;

    localparam logic [2:0] MODE_CONNECTED    = 3'd0;
    localparam logic [2:0] MODE_DISCONNECTED = 3'd1;
    localparam logic [2:0] MODE_PROVISIONING = 3'd2;
    localparam logic [2:0] MODE_IDENTIFY     = 3'd3;
    localparam logic [2:0] MODE_ERASE_ARMED  = 3'd4;
    localparam logic [2:0] MODE_OFF          = 3'd5;

    localparam int unsigned CNT_W = 11;
    localparam logic [CNT_W-1:0] RECHECK_MS = 11'd50;
    localparam logic [CNT_W-1:0] RESET_COUNT = 11'd250;
    localparam logic [CNT_W-1:0] LONGEST_SEGMENT = 11'd1500;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  mode;
        logic [15:0] flash_ms;
    } slps_item_t;

    typedef struct packed {
        logic       led_on;
        logic [2:0] shown_pattern;
        logic       override_active;
    } slps_result_t;

    // Steady modes have a single segment and a fixed level.
    function automatic logic is_steady(input logic [2:0] m);
        return (m == MODE_CONNECTED) || (m == MODE_OFF);
    endfunction

    function automatic logic steady_level(input logic [2:0] m);
        return (m == MODE_CONNECTED);
    endfunction

    // Index of the segment after idx, wrapping at the end of the cycle.
    function automatic logic [1:0] next_index(input logic [2:0] m, input logic [1:0] idx);
        logic [1:0] inc;
        inc = idx + 2'd1;
        if (m == MODE_PROVISIONING) begin
            return inc;
        end
        return {1'b0, inc[0]};
    endfunction

    function automatic logic [CNT_W-1:0] seg_len(input logic [2:0] m, input logic [1:0] idx);
        logic [CNT_W-1:0] len;
        case (m)
            MODE_DISCONNECTED: len = 11'd250;
            MODE_PROVISIONING:
            begin
                case (idx)
                    2'd0:    len = 11'd100;
                    2'd1:    len = 11'd150;
                    2'd2:    len = 11'd100;
                    default: len = 11'd1500;
                endcase
            end
            MODE_IDENTIFY:     len = 11'd100;
            MODE_ERASE_ARMED:  len = 11'd50;
            default:           len = 11'd1000;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/slps_core.sv
// Pattern state and its next-state logic for one word per cycle while step is high.
// Depends on slps_pkg.
`default_nettype none

module slps_core
    import slps_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire slps_item_t   item,
    output slps_result_t      result
);

    logic [2:0]       base_reg, base_next;
    logic [2:0]       cur_reg, cur_next;
    logic [1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             flag_reg, flag_next;
    logic [15:0]      rem_reg, rem_next;
    logic             drive_reg, drive_next;

    logic [15:0] rem_dec;
    logic        mode_ok;
    logic        do_load;
    logic [2:0]  cur_v;
    logic [1:0]  idx_v;
    logic        flag_v;

    always_comb
    begin
        base_next  = base_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        flag_next  = flag_reg;
        rem_next   = rem_reg;
        drive_next = drive_reg;

        rem_dec = (rem_reg != 16'd0) ? (rem_reg - 16'd1) : 16'd0;
        mode_ok = (item.mode <= MODE_OFF);
        do_load = 1'b0;
        cur_v   = cur_reg;
        idx_v   = idx_reg;
        flag_v  = flag_reg;

        case (item.opcode)
            OP_TICK:
            begin
                rem_next = rem_dec;
                if (run_reg) begin
                    if (cnt_reg <= 11'd1) begin
                        // Segment end: an expired flash hands back to the base mode.
                        cnt_next = '0;
                        do_load  = 1'b1;
                        if (flag_reg && (rem_dec == 16'd0)) begin
                            flag_v = 1'b0;
                            cur_v  = base_reg;
                            idx_v  = 2'd0;
                        end else if (!is_steady(cur_reg)) begin
                            idx_v = next_index(cur_reg, idx_reg);
                        end
                    end else begin
                        cnt_next = cnt_reg - 11'd1;
                    end
                end
            end
            OP_SET_BASE:
            begin
                if (mode_ok) begin
                    base_next = item.mode;
                    if (!flag_reg && (item.mode != cur_reg)) begin
                        cur_v   = item.mode;
                        idx_v   = 2'd0;
                        do_load = 1'b1;
                    end
                end
            end
            OP_FLASH:
            begin
                if (mode_ok) begin
                    flag_v   = 1'b1;
                    rem_next = item.flash_ms;
                    cur_v    = item.mode;
                    idx_v    = 2'd0;
                    do_load  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_load) begin
            cur_next  = cur_v;
            idx_next  = idx_v;
            flag_next = flag_v;
            if (is_steady(cur_v)) begin
                drive_next = steady_level(cur_v);
                if (flag_v) begin
                    cnt_next = RECHECK_MS;
                    run_next = 1'b1;
                end else begin
                    run_next = 1'b0;
                end
            end else begin
                drive_next = ~idx_v[0];
                cnt_next   = seg_len(cur_v, idx_v);
                run_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_reg  <= MODE_DISCONNECTED;
            cur_reg   <= MODE_DISCONNECTED;
            idx_reg   <= 2'd0;
            cnt_reg   <= RESET_COUNT;
            run_reg   <= 1'b1;
            flag_reg  <= 1'b0;
            rem_reg   <= 16'd0;
            drive_reg <= 1'b1;
        end else if (step) begin
            base_reg  <= base_next;
            cur_reg   <= cur_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            flag_reg  <= flag_next;
            rem_reg   <= rem_next;
            drive_reg <= drive_next;
        end
    end

    assign result.led_on          = drive_next;
    assign result.shown_pattern   = cur_next;
    assign result.override_active = flag_next;

`ifndef NO_ASSERTIONS
    a_base_shown: assert property (@(posedge clk) disable iff (!rst_n)
        !flag_reg |-> (cur_reg == base_reg))
        else $error("shown mode differs from base mode without a flash");
    a_steady_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (!flag_reg && is_steady(cur_reg)) |-> !run_reg)
        else $error("steady mode without a flash keeps its countdown running");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> ((cnt_reg != '0) && (cnt_reg <= LONGEST_SEGMENT)))
        else $error("running segment countdown out of range");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(cur_reg) && $stable(rem_reg) && $stable(cnt_reg)))
        else $error("pattern state changed with no word processed");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/status_led_pattern_sequencer_top.sv
// Top level of the status LED sequencer: input register, pattern core, result register.
// Depends on slps_pkg and slps_core.
`default_nettype none

// How to use this block:
// Input channel (in_valid, in_stall, opcode, mode, flash_ms) carries one word per
// item: a 1 ms tick, a set-base-mode request or a timed flash request. Output
// channel (out_valid, out_stall, led_on, shown_pattern, override_active) returns
// exactly one result word per input word, in order, giving the LED state after it.
// A word accepted into the input register is processed as it moves on to the result
// register and is offered on the output from then on. Throughput is one word per
// cycle while the receiver does not stall; the core updates the pattern state as
// each word moves on, so each word sees the state left by the one before it.
// When the receiver stalls, the result register holds its word; the input
// register still takes one more word, and in_stall rises only once both are
// full. in_stall follows out_stall in the same cycle.
// Reset (rst_n low, asynchronous) empties both registers and puts the pattern in
// the disconnected mode at its first segment, LED lit, no flash active.
module status_led_pattern_sequencer_top
    import slps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [2:0]  mode,
    input  wire logic [15:0] flash_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             led_on,
    output logic [2:0]       shown_pattern,
    output logic             override_active
);

    logic         in_valid_reg;
    slps_item_t   item_reg;
    logic         out_valid_reg;
    slps_result_t result_reg;
    slps_result_t result;
    logic         out_free;
    logic         advance;
    logic         take_in;

    // The result register can take a word when it is empty or being emptied now.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in) begin
            item_reg.opcode   <= opcode;
            item_reg.mode     <= mode;
            item_reg.flash_ms <= flash_ms;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    slps_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result)
    );

    assign out_valid       = out_valid_reg;
    assign led_on          = result_reg.led_on;
    assign shown_pattern   = result_reg.shown_pattern;
    assign override_active = result_reg.override_active;

endmodule

`default_nettype wire

>>> tb/status_led_pattern_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the status LED sequencer: it drives ticks, base-mode and
// flash requests, predicts the LED state after every word and compares each result.
// Depends on slps_pkg and the status_led_pattern_sequencer_top RTL.

module status_led_pattern_sequencer_top_tb;
    import slps_pkg::*;

    // Opcode 3 has no name in the package; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Modes at or above this value are outside the encoding and get ignored.
    localparam logic [2:0] MODE_LIMIT = 3'd6;
    localparam int unsigned RANDOM_WORDS = 800;
    localparam int unsigned QUIET_TAIL = 150;

    // The scoreboard carries its own copy of the blink state. Every accepted
    // input word advances that state and queues the LED state it leaves
    // behind; every accepted result word is checked against the oldest entry.
    class blink_scoreboard;
        logic [2:0]   home_mode;
        logic [2:0]   disp_mode;
        logic [1:0]   seg_idx;
        logic [10:0]  seg_left;
        bit           seg_running;
        bit           flash_on;
        logic [15:0]  flash_left;
        bit           lit;
        slps_result_t expected_led_states[$];
        int unsigned  mismatch_count;

        function new();
            home_mode      = MODE_DISCONNECTED;
            disp_mode      = MODE_DISCONNECTED;
            seg_idx        = 2'd0;
            seg_left       = 11'd250;
            seg_running    = 1'b1;
            flash_on       = 1'b0;
            flash_left     = 16'd0;
            lit            = 1'b1;
            mismatch_count = 0;
        endfunction

        function logic [10:0] segment_length(input logic [2:0] m, input logic [1:0] idx);
            logic [10:0] len;
            len = 11'd1000;
            if (m == MODE_DISCONNECTED)
                len = 11'd250;
            else if (m == MODE_IDENTIFY)
                len = 11'd100;
            else if (m == MODE_ERASE_ARMED)
                len = 11'd50;
            else if (m == MODE_PROVISIONING)
                len = (idx == 2'd3) ? 11'd1500 : (idx == 2'd1) ? 11'd150 : 11'd100;
            return len;
        endfunction

        function int unsigned segments_in(input logic [2:0] m);
            int unsigned n;
            if (m == MODE_CONNECTED || m == MODE_OFF)
                n = 1;
            else if (m == MODE_PROVISIONING)
                n = 4;
            else
                n = 2;
            return n;
        endfunction

        // Steady modes only run the countdown as a periodic re-check while a
        // flash is active; blinking modes light the LED on even segments.
        function void load_seg();
            if (segments_in(disp_mode) == 1)
            begin
                lit = (disp_mode == MODE_CONNECTED);
                seg_running = flash_on;
                if (flash_on)
                    seg_left = RECHECK_MS;
                return;
            end
            lit = ~seg_idx[0];
            seg_left = segment_length(disp_mode, seg_idx);
            seg_running = 1'b1;
        endfunction

        function void end_segment();
            int unsigned n;
            n = segments_in(disp_mode);
            if (flash_on && flash_left == 16'd0)
            begin
                flash_on = 1'b0;
                disp_mode = home_mode;
                seg_idx = 2'd0;
            end
            else if (n > 1)
                seg_idx = 2'((int'(seg_idx) + 1) % n);
            load_seg();
        endfunction

        function void note_word(input logic [1:0] op, input logic [2:0] m,
                                input logic [15:0] ms);
            slps_result_t res;
            if (op == OP_TICK)
            begin
                if (flash_left != 16'd0)
                    flash_left = flash_left - 16'd1;
                if (seg_running)
                begin
                    if (seg_left <= 11'd1)
                    begin
                        seg_left = 11'd0;
                        end_segment();
                    end
                    else
                        seg_left = seg_left - 11'd1;
                end
            end
            else if (op == OP_SET_BASE && m < MODE_LIMIT)
            begin
                home_mode = m;
                if (!flash_on && m != disp_mode)
                begin
                    disp_mode = m;
                    seg_idx = 2'd0;
                    load_seg();
                end
            end
            else if (op == OP_FLASH && m < MODE_LIMIT)
            begin
                flash_on = 1'b1;
                flash_left = ms;
                disp_mode = m;
                seg_idx = 2'd0;
                load_seg();
            end
            res.led_on = lit;
            res.shown_pattern = disp_mode;
            res.override_active = flash_on;
            expected_led_states.push_back(res);
        endfunction

        function void check_word(input logic led, input logic [2:0] pat, input logic ovr);
            slps_result_t exp_res;
            if (expected_led_states.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual %0d/%0d/%0d",
                         $time, led, pat, ovr);
                mismatch_count++;
                return;
            end
            exp_res = expected_led_states.pop_front();
            if (led !== exp_res.led_on)
            begin
                $display("%0t: led_on expected %0d, actual %0d", $time, exp_res.led_on, led);
                mismatch_count++;
            end
            if (pat !== exp_res.shown_pattern)
            begin
                $display("%0t: shown_pattern expected %0d, actual %0d",
                         $time, exp_res.shown_pattern, pat);
                mismatch_count++;
            end
            if (ovr !== exp_res.override_active)
            begin
                $display("%0t: override_active expected %0d, actual %0d",
                         $time, exp_res.override_active, ovr);
                mismatch_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_led_states.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [2:0]  mode;
    logic [15:0] flash_ms;
    logic        out_valid;
    logic        out_stall;
    logic        led_on;
    logic [2:0]  shown_pattern;
    logic        override_active;

    blink_scoreboard sb;
    // Both sides insert random idle bursts until the last stretch of the run.
    bit idle_enable = 1'b1;

    status_led_pattern_sequencer_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .mode            (mode),
        .flash_ms        (flash_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .led_on          (led_on),
        .shown_pattern   (shown_pattern),
        .override_active (override_active)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one word and hold it until the block takes it. The scoreboard
    // sees the word at the edge where it is accepted, so its order matches
    // the order the block processes words in. A sender gap, when one is
    // drawn, comes before the word is raised so valid never drops while a
    // word is pending.
    task automatic send_word(input logic [1:0] op, input logic [2:0] m, input logic [15:0] ms);
        if (idle_enable && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        mode     <= m;
        flash_ms <= ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(op, m, ms);
    endtask

    task automatic run_ticks(input int unsigned n);
        repeat (n) send_word(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
    endtask

    // Stimulus: a short directed opening, then random scenes of tick runs,
    // base-mode changes and flashes, with a little noise mixed in.
    initial
    begin : word_source
        int unsigned sent;
        int unsigned pick;
        int unsigned n;
        logic [15:0] ms;

        sb = new();
        in_valid <= 1'b0;
        opcode   <= OP_TICK;
        mode     <= MODE_CONNECTED;
        flash_ms <= 16'd0;
        rst_n    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words. The reset state counts down first; then the
        // ignored cases: the unused opcode and both out-of-range modes.
        send_word(OP_TICK, MODE_CONNECTED, 16'd0);
        send_word(OP_UNUSED, 3'd7, 16'hFFFF);
        send_word(OP_SET_BASE, 3'd6, 16'd0);
        send_word(OP_FLASH, 3'd7, 16'hFFFF);
        // Steady on, then a repeat of the same base mode, which must not restart.
        send_word(OP_SET_BASE, MODE_CONNECTED, 16'd0);
        send_word(OP_TICK, MODE_CONNECTED, 16'd0);
        send_word(OP_SET_BASE, MODE_CONNECTED, 16'd0);
        // A zero length flash of the off mode: the flash still restarts it.
        send_word(OP_FLASH, MODE_OFF, 16'd0);
        send_word(OP_TICK, MODE_OFF, 16'd0);
        // A base change under an active flash only updates the base mode.
        send_word(OP_SET_BASE, MODE_IDENTIFY, 16'd0);
        send_word(OP_FLASH, MODE_ERASE_ARMED, 16'hFFFF);
        send_word(OP_TICK, MODE_ERASE_ARMED, 16'd0);
        send_word(OP_FLASH, MODE_CONNECTED, 16'd1);
        send_word(OP_TICK, MODE_CONNECTED, 16'd0);
        send_word(OP_FLASH, MODE_DISCONNECTED, 16'd0);
        send_word(OP_FLASH, MODE_PROVISIONING, 16'd2);
        send_word(OP_FLASH, MODE_IDENTIFY, 16'd0);
        send_word(OP_SET_BASE, MODE_OFF, 16'd0);
        // Let the zero length flash end at the identify segment boundary.
        run_ticks(101);
        send_word(OP_SET_BASE, MODE_PROVISIONING, 16'd0);
        send_word(OP_SET_BASE, MODE_ERASE_ARMED, 16'd0);
        send_word(OP_SET_BASE, MODE_DISCONNECTED, 16'd0);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent > RANDOM_WORDS - QUIET_TAIL)
                idle_enable = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                n = $urandom_range(1, 120);
                run_ticks(n);
                sent += n;
            end
            else if (pick < 75)
            begin
                send_word(OP_SET_BASE, 3'($urandom_range(0, 5)), 16'($urandom_range(0, 65535)));
                sent++;
            end
            else if (pick < 95)
            begin
                // Mostly short flashes so they expire within the run; some
                // take any duration so every bit of the field toggles.
                n = $urandom_range(0, 9);
                if (n < 3)
                    ms = 16'($urandom_range(0, 3));
                else if (n < 8)
                    ms = 16'($urandom_range(0, 300));
                else
                    ms = 16'($urandom_range(0, 65535));
                send_word(OP_FLASH, 3'($urandom_range(0, 5)), ms);
                sent++;
            end
            else if (pick < 97)
                send_word(OP_UNUSED, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
            else
                send_word(2'($urandom_range(1, 2)), 3'($urandom_range(6, 7)),
                          16'($urandom_range(0, 65535)));
        end
        in_valid <= 1'b0;

        // Drain the pipeline, then keep watching the output so a stray extra
        // result word would still be caught.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: check every accepted result word, then choose the stall
    // for the next cycle. Stalls come in random bursts.
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_word(led_on, shown_pattern, override_active);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Guard against a hung handshake: well beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/slps_pkg.sv
hw/rtl/slps_core.sv
hw/rtl/status_led_pattern_sequencer_top.sv
tb/status_led_pattern_sequencer_top_tb.sv
